>>> sv/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

   // Parse phases of the frame header and body.
   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_SECOND = 3'd1,
      PH_EXT16  = 3'd2,
      PH_EXT64  = 3'd3,
      PH_KEY    = 3'd4,
      PH_DATA   = 3'd5,
      PH_SKIP   = 3'd6
   } phase_type;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SHORT     = 2'd1;
   localparam logic [1:0] ST_RESERVED  = 2'd2;
   localparam logic [1:0] ST_TRUNCATED = 2'd3;

   localparam logic [6:0] LEN7_MASK  = 7'h7F;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // Header byte counts at which the extended length is complete.
   localparam logic [3:0] HDR_END_EXT16 = 4'd4;
   localparam logic [3:0] HDR_END_EXT64 = 4'd10;

   // Result queue depth; the input side is held off while fewer than two
   // slots are free.
   localparam int RSP_DEPTH = 3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        fin_bit;
      logic [3:0]  frame_opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [63:0] frame_length;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_item_type;

   // Results caused by one accepted byte, in order.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic rsp_item_type make_done(input logic [1:0] st,
                                              input logic [63:0] total);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_DONE;
      r.status = st;
      r.frame_length = (st == ST_OK) ? total : 64'd0;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/wsd_req_if.sv
`default_nettype none

interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       buffer_end;

   modport source (output valid, output byte_in, output buffer_end, input ready);
   modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

`default_nettype wire

>>> sv/wsd_rsp_if.sv
`default_nettype none

interface wsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic        fin_bit;
   logic [3:0]  frame_opcode;
   logic        masked;
   logic [63:0] payload_length;
   logic [63:0] frame_length;
   logic [1:0]  status;
   logic        last_of_run;

   modport source (output valid, output kind, output data_byte, output fin_bit,
                   output frame_opcode, output masked, output payload_length,
                   output frame_length, output status, output last_of_run,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input fin_bit,
                   input frame_opcode, input masked, input payload_length,
                   input frame_length, input status, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

>>> sv/wsd_parser.sv
`default_nettype none

module wsd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        byte_in,
   input  logic              buffer_end,
   output wsd_pkg::push_type push
);

   wsd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [2:0]  reserved_ff, reserved_in;
   logic        mask_flag_ff, mask_flag_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [63:0] left_ff, left_in;
   logic [1:0]  key_idx_ff, key_idx_in;

   logic [64:0] sum;
   logic [63:0] total;
   logic [63:0] left_dec;
   logic [7:0]  key_byte;
   logic        finish;
   logic        ext_done;
   wsd_pkg::rsp_item_type header;

   assign sum      = {1'b0, length_in} + {61'd0, hdr_count_in};
   assign total    = sum[64] ? '1 : sum[63:0];
   assign left_dec = left_ff - 64'd1;

   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      reserved_in  = reserved_ff;
      mask_flag_in = mask_flag_ff;
      length_in    = length_ff;
      mask_key_in  = mask_key_ff;
      left_in      = left_ff;
      key_idx_in   = key_idx_ff;
      finish       = 1'b0;
      ext_done     = 1'b0;
      push         = '0;

      case (phase_ff)
         wsd_pkg::PH_FIRST: begin
            fin_in       = byte_in[7];
            reserved_in  = byte_in[6:4];
            opcode_in    = byte_in[3:0];
            hdr_count_in = 4'd1;
            phase_in     = wsd_pkg::PH_SECOND;
            if (buffer_end) begin
               push.count = 2'd1;
               push.first = wsd_pkg::make_done(wsd_pkg::ST_SHORT, total);
            end
         end
         wsd_pkg::PH_SECOND: begin
            hdr_count_in = 4'd2;
            mask_flag_in = byte_in[7];
            if (reserved_ff != 3'd0) begin
               push.count = 2'd1;
               push.first = wsd_pkg::make_done(wsd_pkg::ST_RESERVED, total);
               phase_in   = wsd_pkg::PH_SKIP;
            end else begin
               length_in = 64'd0;
               if ((byte_in[6:0] & wsd_pkg::LEN7_MASK) == wsd_pkg::LEN7_EXT16) begin
                  phase_in = wsd_pkg::PH_EXT16;
               end else if (byte_in[6:0] == wsd_pkg::LEN7_EXT64) begin
                  phase_in = wsd_pkg::PH_EXT64;
               end else begin
                  length_in = {57'd0, byte_in[6:0]};
                  if (byte_in[7]) begin
                     phase_in   = wsd_pkg::PH_KEY;
                     key_idx_in = 2'd0;
                  end else begin
                     finish = 1'b1;
                  end
               end
               if (!finish && buffer_end) begin
                  push.count = 2'd1;
                  push.first = wsd_pkg::make_done(wsd_pkg::ST_TRUNCATED, total);
               end
            end
         end
         wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
            length_in    = {length_ff[55:0], byte_in};
            hdr_count_in = hdr_count_ff + 4'd1;
            ext_done = (phase_ff == wsd_pkg::PH_EXT16 &&
                        hdr_count_in == wsd_pkg::HDR_END_EXT16) ||
                       (phase_ff == wsd_pkg::PH_EXT64 &&
                        hdr_count_in == wsd_pkg::HDR_END_EXT64);
            if (ext_done) begin
               if (mask_flag_ff) begin
                  phase_in   = wsd_pkg::PH_KEY;
                  key_idx_in = 2'd0;
               end else begin
                  finish = 1'b1;
               end
            end
            if (!finish && buffer_end) begin
               push.count = 2'd1;
               push.first = wsd_pkg::make_done(wsd_pkg::ST_TRUNCATED, total);
            end
         end
         wsd_pkg::PH_KEY: begin
            mask_key_in  = {mask_key_ff[23:0], byte_in};
            hdr_count_in = hdr_count_ff + 4'd1;
            key_idx_in   = key_idx_ff + 2'd1;
            if (key_idx_in == 2'd0) begin
               finish = 1'b1;
            end else if (buffer_end) begin
               push.count = 2'd1;
               push.first = wsd_pkg::make_done(wsd_pkg::ST_TRUNCATED, total);
            end
         end
         wsd_pkg::PH_DATA: begin
            push.count           = 2'd1;
            push.first.kind      = wsd_pkg::KIND_PAYLOAD;
            push.first.data_byte = mask_flag_ff ? (byte_in ^ key_byte) : byte_in;
            key_idx_in           = key_idx_ff + 2'd1;
            left_in              = left_dec;
            if (left_dec == 64'd0) begin
               push.count  = 2'd2;
               push.second = wsd_pkg::make_done(wsd_pkg::ST_OK, total);
               phase_in    = wsd_pkg::PH_SKIP;
            end else if (buffer_end) begin
               push.count  = 2'd2;
               push.second = wsd_pkg::make_done(wsd_pkg::ST_TRUNCATED, total);
            end
         end
         default: begin
         end
      endcase

      // The header just completed: report it, then finish or enter the payload.
      if (finish) begin
         header                = '0;
         header.kind           = wsd_pkg::KIND_HEADER;
         header.fin_bit        = fin_ff;
         header.frame_opcode   = opcode_ff;
         header.masked         = mask_flag_in;
         header.payload_length = length_in;
         header.frame_length   = total;
         push.first            = header;
         push.count            = 2'd1;
         if (length_in == 64'd0) begin
            push.count  = 2'd2;
            push.second = wsd_pkg::make_done(wsd_pkg::ST_OK, total);
            phase_in    = wsd_pkg::PH_SKIP;
         end else begin
            left_in    = length_in;
            key_idx_in = 2'd0;
            phase_in   = wsd_pkg::PH_DATA;
            if (buffer_end) begin
               push.count  = 2'd2;
               push.second = wsd_pkg::make_done(wsd_pkg::ST_TRUNCATED, total);
            end
         end
      end else begin
         header = '0;
      end

      if (push.count == 2'd1) begin
         push.first.last_of_run = 1'b1;
      end else if (push.count == 2'd2) begin
         push.second.last_of_run = 1'b1;
      end

      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && buffer_end)) begin
         phase_ff     <= wsd_pkg::PH_FIRST;
         hdr_count_ff <= '0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         reserved_ff  <= '0;
         mask_flag_ff <= 1'b0;
         length_ff    <= '0;
         mask_key_ff  <= '0;
         left_ff      <= '0;
         key_idx_ff   <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         reserved_ff  <= reserved_in;
         mask_flag_ff <= mask_flag_in;
         length_ff    <= length_in;
         mask_key_ff  <= mask_key_in;
         left_ff      <= left_in;
         key_idx_ff   <= key_idx_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/wsd_rsp_queue.sv
`default_nettype none

module wsd_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  wsd_pkg::push_type     push,
   output logic                  space_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wsd_pkg::rsp_item_type head
);

   localparam int DEPTH = wsd_pkg::RSP_DEPTH;
   localparam int CW    = $clog2(DEPTH + 1);

   wsd_pkg::rsp_item_type slot_ff [DEPTH];
   wsd_pkg::rsp_item_type slot_in [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] base;
   logic          pop;

   assign pop       = (count_ff != '0) && rsp_ready;
   assign base      = count_ff - CW'(pop);
   assign count_in  = base + CW'(push.count);
   assign space_ok  = count_ff <= CW'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign head      = slot_ff[0];

   // Slot 0 is the output register; the queue shifts down on each pop.
   always_comb begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i+1] : slot_ff[i];
      end
      slot_in[DEPTH-1] = slot_ff[DEPTH-1];
      for (int i = 0; i < DEPTH; i++) begin
         if (push.count != 2'd0 && base == CW'(i)) begin
            slot_in[i] = push.first;
         end
         if (push.count == 2'd2 && base + CW'(1) == CW'(i)) begin
            slot_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/websocket_frame_deframer.sv
`default_nettype none

// Channel   Port       Direction  Item
// -------   --------   ---------  ---------------------------------------------
// request   req_chan   in         one buffer byte and its end-of-buffer flag
// response  rsp_chan   out        header info, payload byte or frame-done status
//
// Each accepted byte updates the parser state in the same cycle and writes
// zero, one or two results into a three-slot response queue whose head is
// the output register. One byte per cycle is taken while at most one result
// is queued, so a byte that causes two results holds off the next byte until a result is popped.
// Reset is synchronous and clears the parser and the queue; a byte flagged
// as buffer end also returns the parser to its reset state.

module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);

   wsd_pkg::push_type     push;
   wsd_pkg::rsp_item_type head;
   logic                  space_ok;
   logic                  accept;

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid && space_ok;

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_in    (req_chan.byte_in),
      .buffer_end (req_chan.buffer_end),
      .push       (push)
   );

   wsd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .head      (head)
   );

   assign rsp_chan.kind           = head.kind;
   assign rsp_chan.data_byte      = head.data_byte;
   assign rsp_chan.fin_bit        = head.fin_bit;
   assign rsp_chan.frame_opcode   = head.frame_opcode;
   assign rsp_chan.masked         = head.masked;
   assign rsp_chan.payload_length = head.payload_length;
   assign rsp_chan.frame_length   = head.frame_length;
   assign rsp_chan.status         = head.status;
   assign rsp_chan.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire
